// ===== hdl/elevator_seek_order_scheduler_defines.svh =====
// Assertion macros for the elevator seek-order scheduler.
// Included by the top level; no other dependencies.
`ifndef ELEVATOR_SEEK_ORDER_SCHEDULER_DEFINES_SVH
`define ELEVATOR_SEEK_ORDER_SCHEDULER_DEFINES_SVH

// expr must hold at every clock edge out of reset
`define ESOS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("esos: invariant violated");

// cons must hold in the cycle after ante
`define ESOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esos: sequence violated");

`endif

// ===== hdl/esos_pkg.sv =====
// Shared constants and types of the elevator seek-order scheduler.
// No dependencies.
package esos_pkg;

    localparam int MaxRequests = 32;
    localparam int CylW        = 16;
    localparam int KindW       = 2;
    localparam int TotW        = 18;
    localparam int TimeW       = 26;
    localparam int SeekW       = 8;
    localparam int ModeW       = 2;
    localparam int CfgIdxW     = 3;

    localparam logic [TotW-1:0] TotalSat = '1;

    localparam logic [KindW-1:0] KIND_HEAD = 2'd0;
    localparam logic [KindW-1:0] KIND_REQ  = 2'd1;
    localparam logic [KindW-1:0] KIND_BND  = 2'd2;

    localparam logic [ModeW-1:0] MODE_SCAN  = 2'd0;
    localparam logic [ModeW-1:0] MODE_CSCAN = 2'd1;
    localparam logic [ModeW-1:0] MODE_LOOK  = 2'd2;
    localparam logic [ModeW-1:0] MODE_CLOOK = 2'd3;

    localparam logic [CfgIdxW-1:0] REG_HEAD  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_LIMIT = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_UP    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_MODE  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SEEK  = 3'd4;

    typedef struct packed {
        logic            ins;
        logic            clr;
        logic [CylW-1:0] x;
    } t_cell_ctl;

endpackage

// ===== hdl/esos_if.sv =====
// Request and stop channel interfaces of the elevator seek-order scheduler.
// Depends on esos_pkg.
interface esos_req_if;
    logic                      valid;
    logic                      ready;
    logic [esos_pkg::CylW-1:0] cylinder;
    logic                      batch_end;
    modport source (output valid, cylinder, batch_end, input ready);
    modport sink   (input valid, cylinder, batch_end, output ready);
endinterface

interface esos_stop_if;
    logic                       valid;
    logic                       ready;
    logic [esos_pkg::CylW-1:0]  stop_position;
    logic [esos_pkg::KindW-1:0] stop_kind;
    logic [esos_pkg::TotW-1:0]  total_cylinders;
    logic [esos_pkg::TimeW-1:0] total_time;
    logic                       overflow_flag;
    logic                       final_stop;
    modport source (output valid, stop_position, stop_kind, total_cylinders, total_time,
                    overflow_flag, final_stop, input ready);
    modport sink   (input valid, stop_position, stop_kind, total_cylinders, total_time,
                    overflow_flag, final_stop, output ready);
endinterface

// ===== hdl/esos_cell.sv =====
// One cell of the insertion-sort chain: holds one cylinder, ascending order.
// Depends on esos_pkg.
module esos_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  esos_pkg::t_cell_ctl       i_ctl,
    input  logic [esos_pkg::CylW-1:0] i_left_val,
    input  logic                      i_left_vld,
    output logic [esos_pkg::CylW-1:0] o_val,
    output logic                      o_vld
);
    logic [esos_pkg::CylW-1:0] r_val, n_val;
    logic                      r_vld, n_vld;

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_ctl.clr) begin
            n_vld = 1'b0;
        end else if (i_ctl.ins && ((r_vld && (i_ctl.x < r_val)) || (!r_vld && i_left_vld))) begin
            n_vld = 1'b1;
            n_val = (i_left_vld && (i_ctl.x < i_left_val)) ? i_left_val : i_ctl.x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_vld = r_vld;
endmodule

// ===== hdl/elevator_seek_order_scheduler.sv =====
// Elevator seek-order scheduler: sorting cell chain plus stop sequencer.
// Depends on esos_pkg, esos_if, esos_cell and the defines header.
// Requests load one per cycle into a chain of MAX_REQUESTS cells that keeps
// them sorted as they arrive. After the request marked batch_end, a scan
// finds the first request above the head. The stops then go out at one per
// cycle while the output accepts them, with an idle step after the first side
// of the order unless the order ends there; the final stop waits for the
// product of total cylinders and seek time before it is offered.
// No request is taken until the last stop is delivered.
`include "elevator_seek_order_scheduler_defines.svh"
module elevator_seek_order_scheduler #(
    parameter int MAX_REQUESTS = esos_pkg::MaxRequests
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    esos_req_if.sink                     i_req,
    esos_stop_if.source                  o_stop,
    input  logic                         i_cfg_we,
    input  logic [esos_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [esos_pkg::CylW-1:0]    i_cfg_data
);
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int SW = $clog2(MAX_REQUESTS + 4);
    localparam int PW = esos_pkg::CylW;

    typedef enum logic [2:0] {ST_LOAD, ST_FIND, ST_EMIT, ST_MUL, ST_LAST} t_state;
    typedef enum logic [2:0] {PH_HEAD, PH_SEG1, PH_B1, PH_B2, PH_SEG2} t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic [PW-1:0]                  r_head, r_limit;
    logic                           r_up;
    logic [esos_pkg::ModeW-1:0]     r_mode;
    logic [esos_pkg::SeekW-1:0]     r_seek;

    logic [CW-1:0] r_count, n_count, r_ptr, n_ptr, r_rem, n_rem, r_nlow, n_nlow;
    logic          r_drop, n_drop;
    logic [SW-1:0] r_left, n_left;
    logic [PW-1:0] r_prev, n_prev;
    logic [esos_pkg::TotW-1:0] r_total, n_total;

    logic                         r_ov, n_ov;
    logic [PW-1:0]                r_opos, n_opos;
    logic [esos_pkg::KindW-1:0]   r_okind, n_okind;
    logic [esos_pkg::TotW-1:0]    r_otot, n_otot;
    logic [esos_pkg::TimeW-1:0]   r_otime, n_otime;
    logic                         r_oovf, n_oovf;
    logic                         r_ofin, n_ofin;

    esos_pkg::t_cell_ctl   w_ctl;
    logic [PW-1:0]         w_v [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] w_vld;
    logic [PW-1:0]         w_rd;

    logic          w_take, w_emit, w_circ, w_bnd, w_s2_asc;
    logic [PW-1:0] w_pos, w_outer, w_diff;
    logic [esos_pkg::KindW-1:0] w_kind;
    logic [esos_pkg::TotW:0]    w_sum;
    logic [esos_pkg::TotW-1:0]  w_sat;
    logic [CW-1:0] w_s1_ptr, w_s1_rem, w_s2_ptr, w_s2_rem, w_upper;
    logic [1:0]    w_nb;

    // sorting chain
    for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
        if (g == 0) begin : g_first
            esos_cell u_cell (
                .i_clk, .i_rst_n, .i_ctl(w_ctl),
                .i_left_val('0), .i_left_vld(1'b1),
                .o_val(w_v[g]), .o_vld(w_vld[g])
            );
        end else begin : g_rest
            esos_cell u_cell (
                .i_clk, .i_rst_n, .i_ctl(w_ctl),
                .i_left_val(w_v[g-1]), .i_left_vld(w_vld[g-1]),
                .o_val(w_v[g]), .o_vld(w_vld[g])
            );
        end
    end

    always_comb begin
        w_rd = '0;
        for (int k = 0; k < MAX_REQUESTS; k++) begin
            if (r_ptr == CW'(k)) w_rd = w_v[k];
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_limit <= PW'(200);
            r_up    <= 1'b1;
            r_mode  <= esos_pkg::MODE_SCAN;
            r_seek  <= esos_pkg::SeekW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                esos_pkg::REG_HEAD:  r_head  <= i_cfg_data;
                esos_pkg::REG_LIMIT: r_limit <= i_cfg_data;
                esos_pkg::REG_UP:    r_up    <= i_cfg_data[0];
                esos_pkg::REG_MODE:  r_mode  <= i_cfg_data[esos_pkg::ModeW-1:0];
                esos_pkg::REG_SEEK:  r_seek  <= i_cfg_data[esos_pkg::SeekW-1:0];
                default: ;
            endcase
        end
    end

    // order shape
    assign w_circ   = (r_mode == esos_pkg::MODE_CSCAN) || (r_mode == esos_pkg::MODE_CLOOK);
    assign w_bnd    = (r_mode == esos_pkg::MODE_SCAN) || (r_mode == esos_pkg::MODE_CSCAN);
    assign w_nb     = (r_mode == esos_pkg::MODE_SCAN) ? 2'd1 :
                      (r_mode == esos_pkg::MODE_CSCAN) ? 2'd2 : 2'd0;
    assign w_outer  = (r_limit == '0) ? '0 : r_limit - PW'(1);
    assign w_upper  = r_count - r_nlow;
    assign w_s1_ptr = r_up ? r_nlow : r_nlow - CW'(1);
    assign w_s1_rem = r_up ? w_upper : r_nlow;
    assign w_s2_asc = r_up ? w_circ : !w_circ;
    assign w_s2_ptr = r_up ? (w_circ ? '0 : r_nlow - CW'(1))
                           : (w_circ ? r_count - CW'(1) : r_nlow);
    assign w_s2_rem = r_up ? r_nlow : w_upper;

    assign w_diff = (w_pos >= r_prev) ? w_pos - r_prev : r_prev - w_pos;
    assign w_sum  = {1'b0, r_total} + (esos_pkg::TotW+1)'(w_diff);
    assign w_sat  = (w_sum > {1'b0, esos_pkg::TotalSat}) ? esos_pkg::TotalSat
                                                       : w_sum[esos_pkg::TotW-1:0];

    assign w_take = r_ov && o_stop.ready;

    always_comb begin
        n_state = r_state;  n_phase = r_phase;
        n_count = r_count;  n_drop  = r_drop;
        n_ptr   = r_ptr;    n_rem   = r_rem;   n_nlow = r_nlow;
        n_left  = r_left;   n_prev  = r_prev;  n_total = r_total;
        n_ov    = w_take ? 1'b0 : r_ov;
        n_opos  = r_opos;   n_okind = r_okind; n_otot = r_otot;
        n_otime = r_otime;  n_oovf  = r_oovf;  n_ofin = r_ofin;
        w_ctl.ins = 1'b0;
        w_ctl.clr = 1'b0;
        w_ctl.x   = i_req.cylinder;
        w_emit = 1'b0;
        w_pos  = r_head;
        w_kind = esos_pkg::KIND_HEAD;

        unique case (r_state)
            ST_LOAD: begin
                if (i_req.valid) begin
                    if (r_count < CW'(MAX_REQUESTS)) begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_req.batch_end) begin
                        n_state = ST_FIND;
                        n_ptr   = '0;
                    end
                end
            end
            ST_FIND: begin
                if ((r_ptr < r_count) && (w_rd <= r_head)) begin
                    n_ptr = r_ptr + CW'(1);
                end else begin
                    n_nlow  = r_ptr;
                    n_state = ST_EMIT;
                    n_phase = PH_HEAD;
                    n_left  = SW'(r_count) + SW'(w_nb) + SW'(1);
                    n_prev  = r_head;
                    n_total = '0;
                end
            end
            ST_EMIT: begin
                if (!r_ov || w_take) begin
                    unique case (r_phase)
                        PH_HEAD: begin
                            w_emit  = 1'b1;
                            n_phase = PH_SEG1;
                            n_ptr   = w_s1_ptr;
                            n_rem   = w_s1_rem;
                        end
                        PH_SEG1, PH_SEG2: begin
                            if (r_rem == '0) begin
                                if (r_phase == PH_SEG1 && w_bnd) begin
                                    n_phase = PH_B1;
                                end else begin
                                    n_phase = PH_SEG2;
                                    n_ptr   = w_s2_ptr;
                                    n_rem   = w_s2_rem;
                                end
                            end else begin
                                w_emit = 1'b1;
                                w_pos  = w_rd;
                                w_kind = esos_pkg::KIND_REQ;
                                n_rem  = r_rem - CW'(1);
                                if ((r_phase == PH_SEG1) ? r_up : w_s2_asc)
                                    n_ptr = r_ptr + CW'(1);
                                else
                                    n_ptr = r_ptr - CW'(1);
                            end
                        end
                        PH_B1: begin
                            w_emit = 1'b1;
                            w_pos  = r_up ? w_outer : '0;
                            w_kind = esos_pkg::KIND_BND;
                            if (w_circ) begin
                                n_phase = PH_B2;
                            end else begin
                                n_phase = PH_SEG2;
                                n_ptr   = w_s2_ptr;
                                n_rem   = w_s2_rem;
                            end
                        end
                        PH_B2: begin
                            w_emit  = 1'b1;
                            w_pos   = r_up ? '0 : w_outer;
                            w_kind  = esos_pkg::KIND_BND;
                            n_phase = PH_SEG2;
                            n_ptr   = w_s2_ptr;
                            n_rem   = w_s2_rem;
                        end
                        default: ;
                    endcase
                    if (w_emit) begin
                        n_prev  = w_pos;
                        n_total = w_sat;
                        n_left  = r_left - SW'(1);
                        n_opos  = w_pos;
                        n_okind = w_kind;
                        n_oovf  = r_drop;
                        n_otime = '0;
                        if (r_left == SW'(1)) begin
                            n_ofin  = 1'b1;
                            n_otot  = w_sat;
                            n_state = ST_MUL;
                        end else begin
                            n_ofin = 1'b0;
                            n_otot = '0;
                            n_ov   = 1'b1;
                        end
                    end
                end
            end
            ST_MUL: begin
                n_otime = esos_pkg::TimeW'(r_otot) * esos_pkg::TimeW'(r_seek);
                n_ov    = 1'b1;
                n_state = ST_LAST;
            end
            ST_LAST: begin
                if (w_take) begin
                    w_ctl.clr = 1'b1;
                    n_count   = '0;
                    n_drop    = 1'b0;
                    n_state   = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_phase <= PH_HEAD;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_ov    <= n_ov;
        end
        r_ptr   <= n_ptr;
        r_rem   <= n_rem;
        r_nlow  <= n_nlow;
        r_left  <= n_left;
        r_prev  <= n_prev;
        r_total <= n_total;
        r_opos  <= n_opos;
        r_okind <= n_okind;
        r_otot  <= n_otot;
        r_otime <= n_otime;
        r_oovf  <= n_oovf;
        r_ofin  <= n_ofin;
    end

    assign i_req.ready            = (r_state == ST_LOAD);
    assign o_stop.valid           = r_ov;
    assign o_stop.stop_position   = r_opos;
    assign o_stop.stop_kind       = r_okind;
    assign o_stop.total_cylinders = r_otot;
    assign o_stop.total_time      = r_otime;
    assign o_stop.overflow_flag   = r_oovf;
    assign o_stop.final_stop      = r_ofin;

    `ESOS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_REQUESTS))
    `ESOS_ASSERT_ALWAYS(a_no_load_while_out, i_clk, i_rst_n, !(i_req.ready && r_ov))
    `ESOS_ASSERT_NEXT(a_final_clears, i_clk, i_rst_n, r_ov && r_ofin && o_stop.ready, r_count == '0 && !r_drop)
    `ESOS_ASSERT_NEXT(a_full_drops, i_clk, i_rst_n, i_req.valid && i_req.ready && r_count == CW'(MAX_REQUESTS), r_drop)
endmodule
